// File: rtl/tiis_pkg.sv
// Shared types and constants for the three-impulse input shaper.
// Used by every module of the block but tiis_ram; no dependencies of its own.
`default_nettype none

package tiis_pkg;

	// Ring store depth; must be a power of two, slot indexes wrap by truncation.
	localparam int STORE_DEPTH   = 256;
	localparam int IMPULSE_COUNT = 3;

	localparam int IDX_W     = $clog2(STORE_DEPTH);
	localparam int SAMPLE_W  = 16;
	localparam int GAIN_W    = 16;
	localparam int DELAY_W   = 8;
	localparam int SLOT_W    = 20;
	localparam int FRAC_W    = 14;
	localparam int PROD_W    = GAIN_W + SAMPLE_W;
	localparam int SCALED_W  = PROD_W - FRAC_W;
	localparam int ADD_W     = SLOT_W + 1;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	localparam logic signed [GAIN_W-1:0] GAIN_FIRST_RST = GAIN_W'(16384);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_FIRST,
		REG_GAIN_SECOND,
		REG_GAIN_THIRD,
		REG_DELAY_FIRST,
		REG_DELAY_SECOND,
		REG_DELAY_THIRD
	} reg_idx_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_first;
		logic signed [GAIN_W-1:0] gain_second;
		logic signed [GAIN_W-1:0] gain_third;
		logic [DELAY_W-1:0]       delay_first;
		logic [DELAY_W-1:0]       delay_second;
		logic [DELAY_W-1:0]       delay_third;
	} cfg_t;

	typedef struct packed {
		logic                       valid;
		logic                       clipped;
		logic signed [SAMPLE_W-1:0] sample;
	} result_t;

	typedef struct packed {
		logic clearing;
		logic busy;
	} status_t;

endpackage

`default_nettype wire

// File: rtl/tiis_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tiis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/tiis_cfg.sv
// Configuration register file: gains and delays of the three impulses.
// Depends on tiis_pkg.
`default_nettype none

module tiis_cfg
	import tiis_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [CFG_DAT_W-1:0] wr_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_first   <= GAIN_FIRST_RST;
			cfg_q.gain_second  <= '0;
			cfg_q.gain_third   <= '0;
			cfg_q.delay_first  <= '0;
			cfg_q.delay_second <= '0;
			cfg_q.delay_third  <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_GAIN_FIRST:   cfg_q.gain_first   <= wr_data[GAIN_W-1:0];
				REG_GAIN_SECOND:  cfg_q.gain_second  <= wr_data[GAIN_W-1:0];
				REG_GAIN_THIRD:   cfg_q.gain_third   <= wr_data[GAIN_W-1:0];
				REG_DELAY_FIRST:  cfg_q.delay_first  <= wr_data[DELAY_W-1:0];
				REG_DELAY_SECOND: cfg_q.delay_second <= wr_data[DELAY_W-1:0];
				REG_DELAY_THIRD:  cfg_q.delay_third  <= wr_data[DELAY_W-1:0];
				default: ;  // unknown index: dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/tiis_core.sv
// Shaper core: sequencer, shared multiplier and saturating adder, ring store
// with forwarding of the last item's pending writes. Depends on tiis_pkg, tiis_ram.
`default_nettype none

module tiis_core
	import tiis_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire cfg_t                       cfg,
	input  wire logic                       in_valid,
	input  wire logic signed [SAMPLE_W-1:0] in_sample,
	input  wire logic                       out_free,
	output logic                            take,
	output result_t                         res,
	output status_t                         status
);

	typedef enum logic [1:0] {ST_IDLE, ST_SUM0, ST_SUM1, ST_SUM2} state_t;
	typedef enum logic [1:0] {WR_NONE, WR_SLOT0, WR_SLOT1, WR_SLOT2} wr_t;

	localparam int SUM_W = ((IDX_W > DELAY_W) ? IDX_W : DELAY_W) + 1;

	function automatic logic [IDX_W-1:0] slot_index(logic [IDX_W-1:0] k,
			logic [DELAY_W-1:0] d);
		logic [SUM_W-1:0] s;
		s = SUM_W'(k) + SUM_W'(d);
		return s[IDX_W-1:0];
	endfunction

	state_t state_q;
	wr_t    wr_q;
	logic   fin_q;
	logic   clr_q;
	logic   fwd_valid_q;
	logic [IDX_W-1:0] clr_cnt_q;
	logic [IDX_W-1:0] k_q;

	logic [IDX_W-1:0] a0_q, a1_q, a2_q;
	logic [IDX_W-1:0] fa0_q, fa1_q, fa2_q;
	logic signed [SLOT_W-1:0] v0_q, v1_q, v2_q;
	logic signed [SLOT_W-1:0] ff1_q, ff2_q;
	logic signed [SAMPLE_W-1:0] cmd_q;
	logic signed [PROD_W-1:0] prod_q;

	logic fin_fire;
	logic [IDX_W-1:0] a0_new, a1_new, a2_new;
	logic [IDX_W-1:0] raddr, cmp_addr, waddr;
	logic [SLOT_W-1:0] rdata, wdata;
	logic we;
	logic signed [SLOT_W-1:0] rd_fix, add_in, add_sat, fin_val, f1, f2;
	logic signed [SCALED_W-1:0] scaled;
	logic signed [ADD_W-1:0] add_sum;
	logic signed [GAIN_W-1:0] mul_g;
	logic signed [SAMPLE_W-1:0] mul_x;
	logic out_ok;

	assign fin_fire = fin_q && out_free;
	assign take     = in_valid && !clr_q && (state_q == ST_IDLE) && (!fin_q || out_free);

	assign a0_new = slot_index(k_q, cfg.delay_first);
	assign a1_new = slot_index(k_q, cfg.delay_second);
	assign a2_new = slot_index(k_q, cfg.delay_third);

	// read issue and compare address per step
	always_comb begin
		unique case (state_q)
			ST_IDLE: begin
				raddr    = a0_new;
				cmp_addr = a0_q;
				mul_g    = cfg.gain_first;
				mul_x    = in_sample;
			end
			ST_SUM0: begin
				raddr    = a1_q;
				cmp_addr = a0_q;
				mul_g    = (IMPULSE_COUNT > 1) ? cfg.gain_second : '0;
				mul_x    = cmd_q;
			end
			ST_SUM1: begin
				raddr    = a2_q;
				cmp_addr = a1_q;
				mul_g    = (IMPULSE_COUNT > 2) ? cfg.gain_third : '0;
				mul_x    = cmd_q;
			end
			ST_SUM2: begin
				raddr    = a2_q;
				cmp_addr = a2_q;
				mul_g    = '0;
				mul_x    = cmd_q;
			end
		endcase
	end

	// last item's writes may not have landed yet
	always_comb begin
		priority if (fwd_valid_q && cmp_addr == fa0_q) begin
			rd_fix = '0;
		end else if (fwd_valid_q && cmp_addr == fa1_q) begin
			rd_fix = ff1_q;
		end else if (fwd_valid_q && cmp_addr == fa2_q) begin
			rd_fix = ff2_q;
		end else begin
			rd_fix = rdata;
		end
	end

	// equal slots within an item chain through the earlier sums
	always_comb begin
		unique case (state_q)
			ST_SUM1: add_in = (a1_q == a0_q) ? v0_q : rd_fix;
			ST_SUM2: add_in = (a2_q == a1_q) ? v1_q : (a2_q == a0_q) ? v0_q : rd_fix;
			default: add_in = rd_fix;
		endcase
	end

	assign scaled  = $signed(prod_q[PROD_W-1:FRAC_W]);
	assign add_sum = ADD_W'(add_in) + ADD_W'(scaled);

	always_comb begin
		if (add_sum[ADD_W-1] != add_sum[ADD_W-2]) begin
			add_sat = add_sum[ADD_W-1] ? {1'b1, {(SLOT_W-1){1'b0}}}
				: {1'b0, {(SLOT_W-1){1'b1}}};
		end else begin
			add_sat = add_sum[SLOT_W-1:0];
		end
	end

	// final slot values of the finished item
	assign fin_val = (a2_q == a0_q) ? v2_q : (a1_q == a0_q) ? v1_q : v0_q;
	assign f1      = (a1_q == a0_q) ? '0 : (a2_q == a1_q) ? v2_q : v1_q;
	assign f2      = (a2_q == a0_q) ? '0 : v2_q;

	assign out_ok = (&fin_val[SLOT_W-1:SAMPLE_W-1]) || !(|fin_val[SLOT_W-1:SAMPLE_W-1]);

	always_comb begin
		res.valid   = fin_q;
		res.clipped = !out_ok;
		if (out_ok) begin
			res.sample = fin_val[SAMPLE_W-1:0];
		end else begin
			res.sample = fin_val[SLOT_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
				: {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	always_comb begin
		we    = 1'b1;
		waddr = clr_cnt_q;
		wdata = '0;
		if (!clr_q) begin
			unique case (wr_q)
				WR_NONE: we = 1'b0;
				WR_SLOT0: waddr = fa0_q;
				WR_SLOT1: begin
					waddr = fa1_q;
					wdata = ff1_q;
				end
				WR_SLOT2: begin
					waddr = fa2_q;
					wdata = ff2_q;
				end
			endcase
		end
	end

	tiis_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fin_q       <= 1'b0;
			wr_q        <= WR_NONE;
			clr_q       <= 1'b1;
			clr_cnt_q   <= '0;
			fwd_valid_q <= 1'b0;
			k_q         <= '0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == IDX_W'(STORE_DEPTH - 1)) begin
					clr_q <= 1'b0;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_SUM0;
						k_q     <= k_q + 1'b1;
					end
				end
				ST_SUM0: state_q <= ST_SUM1;
				ST_SUM1: state_q <= ST_SUM2;
				ST_SUM2: begin
					state_q <= ST_IDLE;
					fin_q   <= 1'b1;
				end
			endcase
			if (fin_fire) begin
				fin_q       <= 1'b0;
				fwd_valid_q <= 1'b1;
				wr_q        <= WR_SLOT0;
			end else begin
				unique case (wr_q)
					WR_NONE:  wr_q <= WR_NONE;
					WR_SLOT0: wr_q <= WR_SLOT1;
					WR_SLOT1: wr_q <= WR_SLOT2;
					WR_SLOT2: wr_q <= WR_NONE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_g * mul_x;
		if (take) begin
			a0_q  <= a0_new;
			a1_q  <= a1_new;
			a2_q  <= a2_new;
			cmd_q <= in_sample;
		end
		if (state_q == ST_SUM0) v0_q <= add_sat;
		if (state_q == ST_SUM1) v1_q <= add_sat;
		if (state_q == ST_SUM2) v2_q <= add_sat;
		if (fin_fire) begin
			fa0_q <= a0_q;
			fa1_q <= a1_q;
			fa2_q <= a2_q;
			ff1_q <= f1;
			ff2_q <= f2;
		end
	end

	assign status.clearing = clr_q;
	assign status.busy     = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// File: rtl/three_impulse_input_shaper_unit.sv
// Three-impulse input shaper. Items do not overlap: the next item is taken only
// when the sequencer is idle again, as an item's three slot reads share the store's
// single read port, and not while a finished result is held by a stalled output.
// Path: input register, 3 summing steps, finished flag, output register.
// Reset: config to reset values, control cleared, then a clearing pass zeroes all
// STORE_DEPTH (256) store slots while s_axis_tready stays low.
`default_nettype none

module three_impulse_input_shaper_unit
	import tiis_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [15:0]          s_axis_tdata,   // [15:0] command_sample
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [15:0]               m_axis_tdata,   // [15:0] shaped_sample
	output logic                      m_axis_tuser,   // [0] clipped
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	cfg_t    cfg;
	result_t res;
	status_t status;
	logic    take;
	logic    out_free;
	logic    in_valid_q;
	logic signed [SAMPLE_W-1:0] in_data_q;
	logic    out_valid_q;
	logic    out_clip_q;
	logic [SAMPLE_W-1:0] out_data_q;

	assign cfg_ready = 1'b1;

	tiis_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid && cfg_ready),
		.wr_index(cfg_index),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	assign s_axis_tready = (!in_valid_q || take) && !status.clearing;
	assign out_free      = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				in_valid_q <= 1'b1;
			end else if (take) begin
				in_valid_q <= 1'b0;
			end
			if (res.valid && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			in_data_q <= s_axis_tdata[SAMPLE_W-1:0];
		end
		if (res.valid && out_free) begin
			out_data_q <= res.sample;
			out_clip_q <= res.clipped;
		end
	end

	tiis_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid_q),
		.in_sample(in_data_q),
		.out_free (out_free),
		.take     (take),
		.res      (res),
		.status   (status)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_clip_q;

`ifndef SYNTHESIS
	// no item enters while the store is being cleared
	a_no_take_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		status.clearing |-> !s_axis_tready && !take)
		else $error("item taken during clearing pass");

	// a finished result is held until the output register frees up
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !out_free |=> res.valid)
		else $error("finished result dropped while output stalled");

	// items never overlap inside the store sequencer
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !status.busy)
		else $error("item started while previous still summing");
`endif

endmodule

`default_nettype wire
